// ===== rtl/dcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_pkg: shared types and constants for the contact force block
// Item kinds, register indexes, operand selects and controller command struct.
// ----------------------------------------------------------------------------
package dcf_pkg;

	localparam int W = 32;

	// item kinds
	localparam logic [1:0] KIND_BODY0   = 2'd0;
	localparam logic [1:0] KIND_BODY1   = 2'd1;
	localparam logic [1:0] KIND_CONTACT = 2'd2;

	// register indexes
	localparam logic [2:0] REG_KN  = 3'd0;
	localparam logic [2:0] REG_DMP = 3'd1;
	localparam logic [2:0] REG_KS  = 3'd2;
	localparam logic [2:0] REG_DT  = 3'd3;
	localparam logic [2:0] REG_MU  = 3'd4;

	// datapath micro-operations, one per sequencer step
	typedef enum logic [5:0] {
		OP_REL     = 6'd0,  // rax, ray, r2x, r2y
		OP_V1X     = 6'd1,  // p = w0 * -ray
		OP_V1Y     = 6'd2,  // v1x ; p = w0 * rax
		OP_V2X     = 6'd3,  // v1y ; p = w1 * -r2y
		OP_V2Y     = 6'd4,  // v2x ; p = w1 * r2x
		OP_DU      = 6'd5,  // v2y
		OP_DUN_A   = 6'd6,  // du ; p = nx*dux
		OP_DUN_B   = 6'd7,  // acc = p ; p = ny*duy
		OP_KN      = 6'd8,  // dun = acc+p ; p = kn*gap
		OP_DMP     = 6'd9,  // acc = -p ; p = damp*dun
		OP_FNX     = 6'd10, // fn ; p = fn*nx
		OP_FNY     = 6'd11, // fx ; p = fn*ny
		OP_DTX     = 6'd12, // fy ; p = dun*nx
		OP_DTY     = 6'd13, // dtx ; p = dun*ny
		OP_SQX     = 6'd14, // dty ; sq = dtx^2 (raw)
		OP_SQY     = 6'd15, // sq += dty^2 ; start sqrt
		OP_SQRT    = 6'd16, // wait sqrt
		OP_FT_A    = 6'd17, // p = ks*dut ; start div x
		OP_FT_B    = 6'd18, // p = ft_a*dt
		OP_CAP     = 6'd19, // ft ; p = mu*fn
		OP_DIVX    = 6'd20, // clamp ft ; wait div x
		OP_DIVY    = 6'd21, // wait div y
		OP_FRX     = 6'd22, // p = ft*tx
		OP_FRY     = 6'd23, // fx -= p ; p = ft*ty
		OP_T1A     = 6'd24, // fy -= p ; p = rax*fy
		OP_T1B     = 6'd25, // acc=p ; p = ray*fx
		OP_T2A     = 6'd26, // t1 ; p = r2y*fx
		OP_T2B     = 6'd27, // acc=p ; p = r2x*fy
		OP_DONE    = 6'd28  // t2 and result
	} op_t;

	typedef struct packed {
		logic load;      // capture input item
		logic step;      // execute op
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic unit_busy; // sqrt or divider running
		logic dut_zero;
	} dp_sts_t;

	function automatic logic signed [W-1:0] sat32(input logic signed [W+1:0] v);
		logic signed [W+1:0] mx;
		logic signed [W+1:0] mn;
		mx = (W+2)'(signed'({1'b0, {(W-1){1'b1}}}));
		mn = -mx - (W+2)'(1);
		if (v > mx) return mx[W-1:0];
		if (v < mn) return mn[W-1:0];
		return v[W-1:0];
	endfunction

endpackage

// ===== rtl/dcf_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_sqrt: iterative integer square root
// Two result bits per cycle over a 64-bit radicand.
// ----------------------------------------------------------------------------
module dcf_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        busy,
	output logic [31:0] root
);
	logic [63:0] x_q;
	logic [31:0] res_q;
	logic [4:0]  cnt_q;
	logic [33:0] rem_q;

	// one root bit per half step, two half steps per cycle
	logic [33:0] r1, r2;
	logic [31:0] q1, q2;
	logic [33:0] t1, t2;
	always_comb begin
		r1 = {rem_q[31:0], x_q[63:62]};
		t1 = {res_q, 2'b01};
		if (r1 >= t1) begin
			r1 = r1 - t1;
			q1 = {res_q[30:0], 1'b1};
		end else begin
			q1 = {res_q[30:0], 1'b0};
		end
		r2 = {r1[31:0], x_q[61:60]};
		t2 = {q1, 2'b01};
		if (r2 >= t2) begin
			r2 = r2 - t2;
			q2 = {q1[30:0], 1'b1};
		end else begin
			q2 = {q1[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 5'd16;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			x_q   <= {x_q[59:0], 4'b0};
			res_q <= q2;
			rem_q <= r2;
		end
	end

	assign busy = (cnt_q != '0);
	assign root = res_q;
endmodule

// ===== rtl/dcf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_div: iterative signed divider
// Quotient of a (W+FRAC) bit magnitude by a 32-bit divisor, truncated toward
// zero and saturated to 32 bits, one bit per cycle.
// ----------------------------------------------------------------------------
module dcf_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic        [31:0] den,
	output logic               busy,
	output logic signed [31:0] quo
);
	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [NW-1:0] q_q;
	logic [32:0]   rem_q;
	logic [31:0]   d_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;

	logic [32:0] trial;
	logic [32:0] sh;
	always_comb begin
		sh    = {rem_q[31:0], n_q[NW-1]};
		trial = sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
			neg_q <= num[31];
			d_q   <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial;
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	// saturate magnitude then apply sign
	logic [NW:0] mag;
	logic [NW:0] sq;
	always_comb begin
		mag = {1'b0, q_q};
		sq  = neg_q ? -mag : mag;
		if (!neg_q && q_q > NW'(32'h7fffffff)) quo = 32'sh7fffffff;
		else if (neg_q && q_q > NW'(33'h80000000)) quo = 32'sh80000000;
		else quo = sq[31:0];
	end

	assign busy = (cnt_q != '0);
endmodule

// ===== rtl/dcf_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_datapath: body state, config registers and one shared multiplier
// Each sequencer step registers one saturated fixed-point product and does
// one add stage on the previous product.
// ----------------------------------------------------------------------------
module dcf_datapath #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dcf_pkg::dp_cmd_t   cmd,
	output dcf_pkg::dp_sts_t   sts,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [1:0]         kind,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] scalar,
	input  logic               second_present,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] torque_first,
	output logic signed [31:0] torque_second,
	output logic               torque_second_valid
);
	typedef logic signed [31:0] s32_t;

	// configuration
	logic [30:0] kn_q, dmp_q, ks_q, dt_q, mu_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kn_q  <= 31'd65536;
			dmp_q <= 31'd0;
			ks_q  <= 31'd65536;
			dt_q  <= 31'd655;
			mu_q  <= 31'd32768;
		end else if (cfg_we) begin
			case (cfg_index)
				dcf_pkg::REG_KN:  kn_q  <= cfg_data[30:0];
				dcf_pkg::REG_DMP: dmp_q <= cfg_data[30:0];
				dcf_pkg::REG_KS:  ks_q  <= cfg_data[30:0];
				dcf_pkg::REG_DT:  dt_q  <= cfg_data[30:0];
				dcf_pkg::REG_MU:  mu_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// body state and captured contact item
	s32_t cx_q [2], cy_q [2], vx_q [2], vy_q [2], w_q [2];
	s32_t px_q, py_q, nx_q, ny_q, gap_q;
	logic two_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				cx_q[i] <= '0; cy_q[i] <= '0; vx_q[i] <= '0;
				vy_q[i] <= '0; w_q[i]  <= '0;
			end
		end else if (cmd.load && (kind == dcf_pkg::KIND_BODY0 ||
				kind == dcf_pkg::KIND_BODY1)) begin
			cx_q[kind[0]] <= pos_x;
			cy_q[kind[0]] <= pos_y;
			vx_q[kind[0]] <= dir_x;
			vy_q[kind[0]] <= dir_y;
			w_q[kind[0]]  <= scalar;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pos_x; py_q <= pos_y; nx_q <= dir_x; ny_q <= dir_y;
			gap_q <= scalar; two_q <= second_present;
		end
	end

	// working registers
	s32_t rax_q, ray_q, r2x_q, r2y_q, v1x_q, v1y_q, v2x_q, v2y_q;
	s32_t dux_q, duy_q, dun_q, fn_q, fx_q, fy_q, dtx_q, dty_q;
	s32_t acc_q, ft_q, tx_q, ty_q, t1_q, t2_q, p_q;
	s32_t fn_new;
	logic [63:0] sq_q;
	logic [31:0] dut_q;

	function automatic s32_t add(input s32_t a, input s32_t b);
		return dcf_pkg::sat32(34'(a) + 34'(b));
	endfunction
	function automatic s32_t sub(input s32_t a, input s32_t b);
		return dcf_pkg::sat32(34'(a) - 34'(b));
	endfunction

	// normal force, clamped at zero, fed straight to the multiplier
	always_comb begin
		fn_new = sub(acc_q, p_q);
		if (fn_new < 0) fn_new = '0;
	end

	// shared multiplier operand select
	s32_t ma, mb;
	always_comb begin
		ma = '0; mb = '0;
		case (cmd.op)
			dcf_pkg::OP_V1X:  begin ma = w_q[0]; mb = sub(32'sd0, ray_q); end
			dcf_pkg::OP_V1Y:  begin ma = w_q[0]; mb = rax_q; end
			dcf_pkg::OP_V2X:  begin ma = w_q[1]; mb = sub(32'sd0, r2y_q); end
			dcf_pkg::OP_V2Y:  begin ma = w_q[1]; mb = r2x_q; end
			dcf_pkg::OP_DUN_A: begin ma = nx_q; mb = sub(v1x_q, v2x_q); end
			dcf_pkg::OP_DUN_B: begin ma = ny_q; mb = duy_q; end
			dcf_pkg::OP_KN:   begin ma = s32_t'({1'b0, kn_q}); mb = gap_q; end
			dcf_pkg::OP_DMP:  begin ma = s32_t'({1'b0, dmp_q}); mb = dun_q; end
			dcf_pkg::OP_FNX:  begin ma = fn_new; mb = nx_q; end
			dcf_pkg::OP_FNY:  begin ma = fn_q; mb = ny_q; end
			dcf_pkg::OP_DTX:  begin ma = dun_q; mb = nx_q; end
			dcf_pkg::OP_DTY:  begin ma = dun_q; mb = ny_q; end
			dcf_pkg::OP_FT_A: begin ma = s32_t'({1'b0, ks_q}); mb = s32_t'(dut_q); end
			dcf_pkg::OP_FT_B: begin ma = p_q; mb = s32_t'({1'b0, dt_q}); end
			dcf_pkg::OP_CAP:  begin ma = s32_t'({1'b0, mu_q}); mb = fn_q; end
			dcf_pkg::OP_FRX:  begin ma = ft_q; mb = tx_q; end
			dcf_pkg::OP_FRY:  begin ma = ft_q; mb = ty_q; end
			dcf_pkg::OP_T1A:  begin ma = rax_q; mb = sub(fy_q, p_q); end
			dcf_pkg::OP_T1B:  begin ma = ray_q; mb = fx_q; end
			dcf_pkg::OP_T2A:  begin ma = r2y_q; mb = fx_q; end
			dcf_pkg::OP_T2B:  begin ma = r2x_q; mb = fy_q; end
			default: ;
		endcase
	end

	// product with floor shift and saturation
	logic signed [63:0] prod;
	logic signed [63:0] shr;
	s32_t fm;
	always_comb begin
		prod = 64'(ma) * 64'(mb);
		shr  = prod >>> FRAC_BITS;
		fm   = dcf_pkg::sat32(shr > 64'sh1_ffff_ffff ? 34'sh1_ffff_ffff :
			shr < -64'sh2_0000_0000 ? -34'sh2_0000_0000 : shr[33:0]);
	end

	// square operands and units
	logic signed [63:0] sqr;
	logic sq_start, dv_start;
	logic sq_busy, dv_busy;
	logic [31:0] root;
	s32_t quo;
	always_comb begin
		sqr = (cmd.op == dcf_pkg::OP_SQX) ? 64'(dtx_q) * 64'(dtx_q) :
			64'(dty_q) * 64'(dty_q);
		sq_start = cmd.step && cmd.op == dcf_pkg::OP_SQY;
		// no division when there is no slip
		dv_start = cmd.step && ((cmd.op == dcf_pkg::OP_FT_A && dut_q != '0) ||
			cmd.op == dcf_pkg::OP_DIVX);
	end

	dcf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.radicand(sq_q + 64'(unsigned'(sqr))), .busy(sq_busy), .root(root)
	);
	dcf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start),
		.num(cmd.op == dcf_pkg::OP_FT_A ? dtx_q : dty_q),
		.den(dut_q), .busy(dv_busy), .quo(quo)
	);

	// sequencer step execution
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			p_q <= fm;
			case (cmd.op)
				dcf_pkg::OP_REL: begin
					rax_q <= sub(px_q, cx_q[0]);
					ray_q <= sub(py_q, cy_q[0]);
					r2x_q <= two_q ? sub(px_q, cx_q[1]) : px_q;
					r2y_q <= two_q ? sub(py_q, cy_q[1]) : py_q;
					v2x_q <= '0;
					v2y_q <= '0;
				end
				dcf_pkg::OP_V1Y: v1x_q <= add(vx_q[0], p_q);
				dcf_pkg::OP_V2X: v1y_q <= add(vy_q[0], p_q);
				dcf_pkg::OP_V2Y: if (two_q) v2x_q <= add(vx_q[1], p_q);
				dcf_pkg::OP_DU:  if (two_q) v2y_q <= add(vy_q[1], p_q);
				dcf_pkg::OP_DUN_A: begin
					dux_q <= sub(v1x_q, v2x_q);
					duy_q <= sub(v1y_q, v2y_q);
				end
				dcf_pkg::OP_DUN_B: acc_q <= p_q;
				dcf_pkg::OP_KN:  dun_q <= add(acc_q, p_q);
				dcf_pkg::OP_DMP: acc_q <= sub(32'sd0, p_q);
				dcf_pkg::OP_FNX: fn_q <= fn_new;
				dcf_pkg::OP_FNY: fx_q <= p_q;
				dcf_pkg::OP_DTX: fy_q <= p_q;
				dcf_pkg::OP_DTY: dtx_q <= sub(dux_q, p_q);
				dcf_pkg::OP_SQX: begin
					dty_q <= sub(duy_q, p_q);
					sq_q  <= 64'(unsigned'(sqr));
				end
				dcf_pkg::OP_FT_A: ;
				dcf_pkg::OP_CAP: ft_q <= p_q;
				dcf_pkg::OP_DIVX: begin
					if (ft_q < 0) ft_q <= '0;
					else if (ft_q > p_q) ft_q <= p_q;
					tx_q <= quo;
				end
				dcf_pkg::OP_DIVY: ty_q <= quo;
				dcf_pkg::OP_FRY: fx_q <= sub(fx_q, p_q);
				dcf_pkg::OP_T1A: fy_q <= sub(fy_q, p_q);
				dcf_pkg::OP_T1B: acc_q <= p_q;
				dcf_pkg::OP_T2A: t1_q <= sub(acc_q, p_q);
				dcf_pkg::OP_T2B: acc_q <= p_q;
				dcf_pkg::OP_DONE: t2_q <= two_q ? sub(acc_q, p_q) : '0;
				default: ;
			endcase
		end
		if (cmd.step && cmd.op == dcf_pkg::OP_SQRT && !sq_busy) begin
			dut_q <= root[31] ? 32'h7fffffff : root;
		end
	end

	assign sts.unit_busy = sq_busy | dv_busy;
	assign sts.dut_zero  = (dut_q == '0);

	assign force_x             = fx_q;
	assign force_y             = fy_q;
	assign torque_first        = t1_q;
	assign torque_second       = t2_q;
	assign torque_second_valid = two_q;
endmodule

// ===== rtl/dcf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_ctrl: controller for the contact step
// Accepts items, steps the datapath through its op sequence, waits on the
// iterative units and holds the result until the output transaction.
// ----------------------------------------------------------------------------
module dcf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	output logic              out_valid,
	input  logic              out_stall,
	output dcf_pkg::dp_cmd_t  cmd,
	input  dcf_pkg::dp_sts_t  sts
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t      state_q;
	dcf_pkg::op_t op_q;

	logic accept;
	logic waiting;
	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	// iterative units hold the sequence at their wait steps
	assign waiting = (op_q == dcf_pkg::OP_SQRT || op_q == dcf_pkg::OP_DIVX ||
		op_q == dcf_pkg::OP_DIVY) && sts.unit_busy;

	always_comb begin
		cmd.load = accept;
		cmd.step = (state_q == ST_RUN) && !waiting;
		cmd.op   = op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= dcf_pkg::OP_REL;
		end else begin
			case (state_q)
				ST_IDLE: if (accept && kind == dcf_pkg::KIND_CONTACT) begin
					state_q <= ST_RUN;
					op_q    <= dcf_pkg::OP_REL;
				end
				ST_RUN: if (!waiting) begin
					if (op_q == dcf_pkg::OP_DONE) begin
						state_q <= ST_OUT;
					end else if (op_q == dcf_pkg::OP_FT_A && sts.dut_zero) begin
						// no friction when the tangential speed is zero
						op_q <= dcf_pkg::OP_T1A;
					end else begin
						op_q <= dcf_pkg::op_t'(op_q + 6'd1);
					end
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/dem_contact_force.sv =====
`timescale 1ns / 1ps
// Timing: a load transaction is taken while the controller is idle; a contact result
// leaves after the square root, two serial divisions and the shared multiplier steps;
// with no tangential slip the divisions and friction steps are skipped.
// Throughput: one item at a time; loads every cycle, a contact blocks the input
// until its result leaves.
// Reset: arst_n clears body state, control and restores register defaults.
// ----------------------------------------------------------------------------
// dem_contact_force: 2D spring-dashpot contact force with Coulomb friction
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
module dem_contact_force #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] scalar,
	input  logic               second_present,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] torque_first,
	output logic signed [31:0] torque_second,
	output logic               torque_second_valid
);
	dcf_pkg::dp_cmd_t cmd;
	dcf_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	dcf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .sts(sts)
	);

	dcf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.kind(kind), .pos_x(pos_x), .pos_y(pos_y), .dir_x(dir_x), .dir_y(dir_y),
		.scalar(scalar), .second_present(second_present),
		.force_x(force_x), .force_y(force_y), .torque_first(torque_first),
		.torque_second(torque_second), .torque_second_valid(torque_second_valid)
	);
endmodule

// ===== rtl/dcf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcf_checker: port-level checks for the contact force block
// Handshake and result checks, bound to the top level.
// ----------------------------------------------------------------------------
module dcf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic torque_second_valid,
	input logic signed [31:0] torque_second,
	input logic signed [31:0] force_x
);
	// no input taken while a result is pending
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken with result pending");

	// absent second body gives zero torque
	a_t2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !torque_second_valid |-> torque_second == '0)
		else $error("torque_second nonzero without second body");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(force_x))
		else $error("stalled result changed");
endmodule

bind dem_contact_force dcf_checker u_dcf_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.torque_second_valid(torque_second_valid), .torque_second(torque_second),
	.force_x(force_x)
);

// ===== tb/sv/tb_dem_contact_force.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dem_contact_force: self-checking bench for the contact force block
// Loads body states and issues contact transactions, directed then random,
// with random idle bursts on both sides and one long output hold-off. Each
// result is predicted in fixed point and compared field by field in order.
// ----------------------------------------------------------------------------
module tb_dem_contact_force;

	localparam int FB = 16;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] px, py, dx, dy, sc;
		logic        two;
	} item_t;

	typedef struct packed {
		logic [31:0] fx, fy, t1, t2;
		logic        t2v;
	} force_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, dir_x = '0, dir_y = '0, scalar = '0;
	logic second_present = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] force_x, force_y, torque_first, torque_second;
	logic torque_second_valid;

	dem_contact_force #(.FRAC_BITS(FB)) u_top (.*);

	always #2 clk = ~clk;

	// predictor state
	longint kn, damp, ks, dt, mu;
	longint cx[2], cy[2], vx[2], vy[2], w[2];

	item_t  pending_items[$];
	force_t expected_forces[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	bit     quiet_tail = 0;
	bit     hold_off = 0;
	int     in_gap = 0, out_gap = 0;

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// exact product, arithmetic shift floors toward minus infinity
	function automatic longint qmul(longint a, longint b);
		return sat((a * b) >>> FB);
	endfunction

	function automatic longint root64(longint unsigned x);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic void contact_force(item_t it);
		longint px, py, nx, ny, gap, rax, ray, r2x, r2y, v1x, v1y, v2x, v2y;
		longint dux, duy, dun, fn, fx, fy, dtx, dty, dut, tx, ty, ft, cap, t1, t2;
		longint unsigned sq;
		force_t r;
		px = longint'($signed(it.px)); py = longint'($signed(it.py));
		nx = longint'($signed(it.dx)); ny = longint'($signed(it.dy));
		gap = longint'($signed(it.sc));
		if (it.kind == dcf_pkg::KIND_BODY0 || it.kind == dcf_pkg::KIND_BODY1) begin
			cx[it.kind[0]] = px; cy[it.kind[0]] = py;
			vx[it.kind[0]] = nx; vy[it.kind[0]] = ny; w[it.kind[0]] = gap;
			return;
		end
		if (it.kind != dcf_pkg::KIND_CONTACT) return;
		rax = sat(px - cx[0]); ray = sat(py - cy[0]);
		r2x = px; r2y = py; v2x = 0; v2y = 0;
		v1x = sat(vx[0] + qmul(w[0], sat(-ray)));
		v1y = sat(vy[0] + qmul(w[0], rax));
		if (it.two) begin
			r2x = sat(px - cx[1]); r2y = sat(py - cy[1]);
			v2x = sat(vx[1] + qmul(w[1], sat(-r2y)));
			v2y = sat(vy[1] + qmul(w[1], r2x));
		end
		dux = sat(v1x - v2x); duy = sat(v1y - v2y);
		dun = sat(qmul(nx, dux) + qmul(ny, duy));
		fn = sat(sat(-qmul(kn, gap)) - qmul(damp, dun));
		if (fn < 0) fn = 0;
		fx = qmul(fn, nx); fy = qmul(fn, ny);
		dtx = sat(dux - qmul(dun, nx)); dty = sat(duy - qmul(dun, ny));
		sq = longint'(dtx * dtx) + longint'(dty * dty);
		dut = root64(sq);
		if (dut > 64'sd2147483647) dut = 64'sd2147483647;
		// friction only when there is tangential slip
		if (dut > 0) begin
			tx = sat((dtx * (64'sd1 << FB)) / dut);
			ty = sat((dty * (64'sd1 << FB)) / dut);
			ft = qmul(qmul(ks, dut), dt);
			cap = qmul(mu, fn);
			if (ft < 0) ft = 0;
			if (ft > cap) ft = cap;
			fx = sat(fx - qmul(ft, tx));
			fy = sat(fy - qmul(ft, ty));
		end
		t1 = sat(qmul(rax, fy) - qmul(ray, fx));
		t2 = it.two ? sat(qmul(r2y, fx) - qmul(r2x, fy)) : 0;
		r.fx = fx[31:0]; r.fy = fy[31:0]; r.t1 = t1[31:0]; r.t2 = t2[31:0];
		r.t2v = it.two;
		expected_forces.push_back(r);
	endfunction

	function automatic logic [31:0] rand_val(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
			2: return 32'(int'($urandom_range(0, 2 << FB)) - (1 << FB));
			default: return $urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
	endfunction

	function automatic item_t rand_item(logic [1:0] k);
		item_t it;
		int m;
		m = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 19) == 0 ? 3 : 1);
		it.kind = k;
		it.px = rand_val(m); it.py = rand_val(m);
		it.dx = rand_val(m == 1 ? 2 : m); it.dy = rand_val(m == 1 ? 2 : m);
		it.sc = rand_val(m);
		it.two = 1'($urandom);
		return it;
	endfunction

	function automatic item_t mk(logic [1:0] k, logic [31:0] px, py, dx, dy, sc, logic two);
		item_t it;
		it.kind = k; it.px = px; it.py = py; it.dx = dx; it.dy = dy; it.sc = sc;
		it.two = two;
		return it;
	endfunction

	// driver: idle bursts, payload held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				contact_force(pending_items.pop_front());
			end
			if (!(in_valid && in_stall)) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					if (!quiet_tail && $urandom_range(0, 9) == 0) begin
						in_gap <= $urandom_range(0, 7);
						in_valid <= 1'b0;
					end else begin
						in_valid <= 1'b1;
						kind <= pending_items[0].kind;
						pos_x <= pending_items[0].px; pos_y <= pending_items[0].py;
						dir_x <= pending_items[0].dx; dir_y <= pending_items[0].dy;
						scalar <= pending_items[0].sc;
						second_present <= pending_items[0].two;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare against the oldest expected result
	always @(posedge clk) begin
		force_t got, exp_r;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {force_x, force_y, torque_first, torque_second, torque_second_valid};
				if (expected_forces.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %h", got);
				end else begin
					exp_r = expected_forces.pop_front();
					if (got !== exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch fx %h/%h fy %h/%h t1 %h/%h t2 %h/%h v %b/%b",
								exp_r.fx, got.fx, exp_r.fy, got.fy, exp_r.t1, got.t1,
								exp_r.t2, got.t2, exp_r.t2v, got.t2v);
					end
				end
			end
			if (hold_off) out_stall <= 1'b1;
			else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_stall <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				out_gap <= $urandom_range(0, 7);
				out_stall <= 1'b1;
			end else out_stall <= 1'b0;
		end
	end

	// watchdog on transaction progress
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			dcf_pkg::REG_KN:  kn = val[30:0];
			dcf_pkg::REG_DMP: damp = val[30:0];
			dcf_pkg::REG_KS:  ks = val[30:0];
			dcf_pkg::REG_DT:  dt = val[30:0];
			dcf_pkg::REG_MU:  mu = val[30:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_forces.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic random_phase(int n, bit wellformed);
		item_t it;
		for (int i = 0; i < n; i++) begin
			if (wellformed && $urandom_range(0, 4) != 0) begin
				pending_items.push_back(rand_item(dcf_pkg::KIND_BODY0));
				pending_items.push_back(rand_item(dcf_pkg::KIND_BODY1));
				pending_items.push_back(rand_item(dcf_pkg::KIND_CONTACT));
				i += 2;
			end else begin
				it = rand_item(2'($urandom_range(0, 3)));
				pending_items.push_back(it);
			end
		end
	endtask

	initial begin
		kn = 65536; damp = 0; ks = 65536; dt = 655; mu = 32768;
		for (int i = 0; i < 2; i++) begin
			cx[i] = 0; cy[i] = 0; vx[i] = 0; vy[i] = 0; w[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: zero state, extremes, no second body, no slip, unused kind
		pending_items.push_back(mk(dcf_pkg::KIND_CONTACT, 0, 0, 32'h0001_0000, 0,
			32'hFFFF_0000, 0));
		pending_items.push_back(mk(dcf_pkg::KIND_BODY0, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1));
		pending_items.push_back(mk(dcf_pkg::KIND_BODY1, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
		pending_items.push_back(mk(dcf_pkg::KIND_CONTACT, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1));
		pending_items.push_back(mk(dcf_pkg::KIND_CONTACT, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
		pending_items.push_back(mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1));
		pending_items.push_back(mk(dcf_pkg::KIND_BODY0, 0, 0, 0, 32'h0000_8000, 0, 0));
		pending_items.push_back(mk(dcf_pkg::KIND_BODY1, 0, 0, 0, 32'h0000_8000, 0, 1));
		pending_items.push_back(mk(dcf_pkg::KIND_CONTACT, 0, 0, 0, 32'h0001_0000,
			32'hFFFF_8000, 1));
		pending_items.push_back(mk(dcf_pkg::KIND_BODY0, 32'h0002_0000, 0, 32'h0001_0000,
			32'h0003_0000, 32'h0000_4000, 0));
		pending_items.push_back(mk(dcf_pkg::KIND_CONTACT, 32'h0003_0000, 32'h0001_0000,
			32'h0001_0000, 0, 32'hFFFE_0000, 0));
		pending_items.push_back(mk(dcf_pkg::KIND_CONTACT, 32'h0003_0000, 32'h0001_0000,
			32'h0001_0000, 0, 32'h0002_0000, 1));
		drain();

		// register settings, extremes included, random traffic in each
		write_reg(dcf_pkg::REG_KN, 32'hFFFF_FFFF); write_reg(dcf_pkg::REG_DMP, 32'h7FFF_FFFF);
		write_reg(dcf_pkg::REG_KS, 32'h7FFF_FFFF); write_reg(dcf_pkg::REG_DT, 32'h7FFF_FFFF);
		write_reg(dcf_pkg::REG_MU, 32'h7FFF_FFFF); write_reg(3'd7, 32'h1234_5678);
		random_phase(80, 1);
		drain();
		write_reg(dcf_pkg::REG_KN, 0); write_reg(dcf_pkg::REG_DMP, 0);
		write_reg(dcf_pkg::REG_KS, 0); write_reg(dcf_pkg::REG_DT, 0);
		write_reg(dcf_pkg::REG_MU, 0);
		random_phase(60, 1);
		drain();
		write_reg(dcf_pkg::REG_KN, 32'h0004_0000); write_reg(dcf_pkg::REG_DMP, 32'h0000_8000);
		write_reg(dcf_pkg::REG_KS, 32'h0010_0000); write_reg(dcf_pkg::REG_DT, 32'h0000_4000);
		write_reg(dcf_pkg::REG_MU, 32'h0000_C000);

		// long output hold-off while input keeps coming
		random_phase(30, 1);
		hold_off = 1;
		repeat (600) @(posedge clk);
		hold_off = 0;
		random_phase(180, 1);
		drain();
		write_reg(dcf_pkg::REG_KN, $urandom);
		write_reg(dcf_pkg::REG_DMP, $urandom_range(0, 1 << 17));
		write_reg(dcf_pkg::REG_KS, $urandom);
		write_reg(dcf_pkg::REG_DT, $urandom_range(0, 1 << 16));
		write_reg(dcf_pkg::REG_MU, $urandom_range(0, 1 << 17));
		random_phase(140, 1);
		while (pending_items.size() > 40) @(posedge clk);
		quiet_tail = 1;
		random_phase(40, 1);
		drain();

		if (mismatches == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
